/* rtl/core/charger_status_debounce_monitor_unit_assert.svh */
// assertion helpers for the charger status monitor
`ifndef CHARGER_STATUS_DEBOUNCE_MONITOR_UNIT_ASSERT_SVH
`define CHARGER_STATUS_DEBOUNCE_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charger monitor check failed");

// next-cycle implication, checked out of reset
`define CSDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charger monitor sequence check failed");

`endif

/* rtl/core/csdm_pkg.sv */
`timescale 1ns / 1ps

package csdm_pkg;

    localparam int SAMPLE_PERIOD   = 50;
    localparam int REMINDER_PERIOD = 90;

    // residue counters track charge_ticks modulo each period
    localparam int SAMPLE_W   = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
    localparam int REMINDER_W = (REMINDER_PERIOD > 1) ? $clog2(REMINDER_PERIOD) : 1;

    localparam logic [7:0] DEBOUNCE_TICKS_RST     = 8'd3;
    localparam logic [7:0] FULL_CONFIRM_TICKS_RST = 8'd5;
    localparam logic [6:0] FULL_PERCENT_RST       = 7'd95;
    localparam logic       FULL_PIN_ENABLE_RST    = 1'b1;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE_TICKS     = 2'd0,
        CFG_FULL_CONFIRM_TICKS = 2'd1,
        CFG_FULL_PERCENT       = 2'd2,
        CFG_FULL_PIN_ENABLE    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        REM_NONE     = 2'd0,
        REM_CHARGING = 2'd1,
        REM_FULL     = 2'd2
    } t_reminder;

    typedef struct packed {
        logic       charging_pin;
        logic       full_pin;
        logic [6:0] battery_percent;
        logic       alarm_wakeup;
    } t_in_item;

    typedef struct packed {
        logic       charge_started;
        logic       play_charging_sound;
        logic       full_notice;
        logic       play_full_sound;
        logic [1:0] reminder;
        logic       display_update;
        logic       charging_state;
        logic       full_confirmed;
    } t_out_item;

endpackage

/* rtl/core/charger_status_debounce_monitor_unit.sv */
`timescale 1ns / 1ps
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+-----------------------
// in        | input     | i_in_valid / o_in_stall   | i_in  (t_in_item)
// out       | output    | o_out_valid / i_out_stall | o_out (t_out_item)
// cfg       | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one tick beat per cycle unless the output stalls; a beat passes through the
// input register, then one pass of counter/compare logic into the result register
// synchronous active-low reset restores register defaults and clears all tick state
// an output stall holds the result register and the input register behind it
// cfg writes are always ready and take effect on the next cycle

`include "charger_status_debounce_monitor_unit_assert.svh"

module charger_status_debounce_monitor_unit
    import csdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // configuration
    logic [7:0] r_debounce_ticks;
    logic [7:0] r_full_confirm_ticks;
    logic [6:0] r_full_percent;
    logic       r_full_pin_enable;

    // pipeline
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_free;
    logic      fire;

    // tick state
    logic                  r_last_raw,          n_last_raw;
    logic                  r_last_debounced,    n_last_debounced;
    logic [7:0]            r_stable_count,      n_stable_count;
    logic [7:0]            r_full_seen_count,   n_full_seen_count;
    logic [7:0]            r_full_absent_count, n_full_absent_count;
    logic                  r_full_flag,         n_full_flag;
    logic                  r_notified_full,     n_notified_full;
    logic [15:0]           r_charge_ticks,      n_charge_ticks;
    logic [SAMPLE_W-1:0]   r_sample_res,        n_sample_res;
    logic [REMINDER_W-1:0] r_remind_res,        n_remind_res;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !out_free;
    assign fire        = r_in_vld && out_free;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks     <= DEBOUNCE_TICKS_RST;
            r_full_confirm_ticks <= FULL_CONFIRM_TICKS_RST;
            r_full_percent       <= FULL_PERCENT_RST;
            r_full_pin_enable    <= FULL_PIN_ENABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:     r_debounce_ticks     <= i_cfg_data;
                CFG_FULL_CONFIRM_TICKS: r_full_confirm_ticks <= i_cfg_data;
                CFG_FULL_PERCENT:       r_full_percent       <= i_cfg_data[6:0];
                CFG_FULL_PIN_ENABLE:    r_full_pin_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw          <= 1'b0;
            r_last_debounced    <= 1'b0;
            r_stable_count      <= '0;
            r_full_seen_count   <= '0;
            r_full_absent_count <= '0;
            r_full_flag         <= 1'b0;
            r_notified_full     <= 1'b0;
            r_charge_ticks      <= '0;
            r_sample_res        <= '0;
            r_remind_res        <= '0;
        end else if (fire) begin
            r_last_raw          <= n_last_raw;
            r_last_debounced    <= n_last_debounced;
            r_stable_count      <= n_stable_count;
            r_full_seen_count   <= n_full_seen_count;
            r_full_absent_count <= n_full_absent_count;
            r_full_flag         <= n_full_flag;
            r_notified_full     <= n_notified_full;
            r_charge_ticks      <= n_charge_ticks;
            r_sample_res        <= n_sample_res;
            r_remind_res        <= n_remind_res;
        end
    end

    always_comb begin
        logic                  both;
        logic                  accepted;
        logic                  started;
        logic                  notice;
        logic [6:0]            sampled;
        logic [15:0]           ticks;
        logic [SAMPLE_W-1:0]   s_res;
        logic [REMINDER_W-1:0] r_res;
        t_reminder             rem;

        n_full_seen_count   = r_full_seen_count;
        n_full_absent_count = r_full_absent_count;
        n_full_flag         = r_full_flag;
        n_notified_full     = r_notified_full;
        n_charge_ticks      = r_charge_ticks;
        n_sample_res        = r_sample_res;
        n_remind_res        = r_remind_res;
        n_last_debounced    = r_last_debounced;
        started             = 1'b0;
        notice              = 1'b0;
        sampled             = '0;
        ticks               = r_charge_ticks;
        s_res               = r_sample_res;
        r_res               = r_remind_res;
        rem                 = REM_NONE;

        // full pin confirmation, counters saturate
        both = r_in.full_pin && r_in.charging_pin;
        if (r_full_pin_enable) begin
            if (both) begin
                n_full_seen_count   = (r_full_seen_count == 8'hFF) ? 8'hFF
                                    : r_full_seen_count + 8'd1;
                n_full_absent_count = '0;
                if (n_full_seen_count > r_full_confirm_ticks) begin
                    n_full_flag = 1'b1;
                end
            end else begin
                n_full_seen_count   = '0;
                n_full_absent_count = (r_full_absent_count == 8'hFF) ? 8'hFF
                                    : r_full_absent_count + 8'd1;
                if (n_full_absent_count > r_full_confirm_ticks) begin
                    n_full_flag = 1'b0;
                end
            end
        end

        n_last_raw = r_in.charging_pin;
        if (r_last_raw != r_in.charging_pin) begin
            n_stable_count = 8'd1;
        end else begin
            n_stable_count = (r_stable_count == 8'hFF) ? 8'hFF : r_stable_count + 8'd1;
        end

        accepted = n_stable_count >= r_debounce_ticks;

        if (accepted && r_in.charging_pin) begin
            if (!r_last_debounced) begin
                started = 1'b1;
                ticks   = '0;
                s_res   = '0;
                r_res   = '0;
            end
            // percent only counts on a sample tick
            sampled = (s_res == '0) ? r_in.battery_percent : 7'd0;
            if (!r_notified_full && (n_full_flag || sampled >= r_full_percent)) begin
                notice          = 1'b1;
                n_notified_full = 1'b1;
            end
            n_charge_ticks = ticks + 16'd1;
            // residues restart when the 16-bit count wraps
            if (ticks == 16'hFFFF) begin
                n_sample_res = '0;
                n_remind_res = '0;
            end else begin
                n_sample_res = (s_res == SAMPLE_W'(SAMPLE_PERIOD - 1)) ? '0
                             : s_res + SAMPLE_W'(1);
                n_remind_res = (r_res == REMINDER_W'(REMINDER_PERIOD - 1)) ? '0
                             : r_res + REMINDER_W'(1);
            end
            if (n_remind_res == '0) begin
                rem = n_notified_full ? REM_FULL : REM_CHARGING;
            end
        end else if (accepted) begin
            n_notified_full = 1'b0;
            n_full_flag     = 1'b0;
            n_charge_ticks  = '0;
            n_sample_res    = '0;
            n_remind_res    = '0;
        end

        if (accepted) begin
            n_last_debounced = r_in.charging_pin;
        end

        n_out.charge_started      = started;
        n_out.play_charging_sound = started && !r_in.alarm_wakeup;
        n_out.full_notice         = notice;
        n_out.play_full_sound     = notice && !r_in.alarm_wakeup;
        n_out.reminder            = rem;
        n_out.display_update      = accepted && (r_last_debounced != r_in.charging_pin);
        n_out.charging_state      = n_last_debounced;
        n_out.full_confirmed      = n_full_flag;
    end

    `CSDM_ASSERT_NOW(a_notice_while_charging, i_clk, i_rst_n, o_out_valid && o_out.full_notice, o_out.charging_state)
    `CSDM_ASSERT_NOW(a_reminder_while_charging, i_clk, i_rst_n, o_out_valid && (o_out.reminder != REM_NONE), o_out.charging_state)
    `CSDM_ASSERT_NOW(a_start_refreshes, i_clk, i_rst_n, o_out_valid && o_out.charge_started, o_out.display_update && o_out.charging_state)
    `CSDM_ASSERT_NEXT(a_input_reg_holds, i_clk, i_rst_n, r_in_vld && r_out_vld && i_out_stall, r_in_vld && $stable(r_in))

endmodule

/* bench/charge_tick_checker.sv */
`timescale 1ns / 1ps

module charge_tick_checker
    import csdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    // register copies
    logic [7:0] deb_ticks;
    logic [7:0] confirm_ticks;
    logic [6:0] full_pct;
    logic       pin_en;

    // tick state
    logic        last_raw;
    logic        last_deb;
    logic [7:0]  stable_cnt;
    logic [7:0]  seen_cnt;
    logic [7:0]  absent_cnt;
    logic        full_flag;
    logic        notified;
    logic [15:0] charge_ticks;

    t_out_item expected_ticks[$];
    int        result_no = 0;

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic t_out_item predict_tick(t_in_item t);
        t_out_item   r;
        logic [6:0]  sampled;
        r = '0;
        if (pin_en) begin
            if (t.full_pin && t.charging_pin) begin
                seen_cnt   = sat_inc(seen_cnt);
                absent_cnt = 8'd0;
                if (seen_cnt > confirm_ticks) full_flag = 1'b1;
            end else begin
                seen_cnt   = 8'd0;
                absent_cnt = sat_inc(absent_cnt);
                if (absent_cnt > confirm_ticks) full_flag = 1'b0;
            end
        end
        if (last_raw != t.charging_pin) begin
            stable_cnt = 8'd1;
            last_raw   = t.charging_pin;
        end else begin
            stable_cnt = sat_inc(stable_cnt);
        end
        if (stable_cnt >= deb_ticks) begin
            if (t.charging_pin) begin
                if (!last_deb) begin
                    r.charge_started = 1'b1;
                    charge_ticks     = 16'd0;
                end
                // percent only counts on sample ticks, reads as zero otherwise
                sampled = (charge_ticks % SAMPLE_PERIOD == 0) ? t.battery_percent : 7'd0;
                if (!notified && (full_flag || sampled >= full_pct)) begin
                    notified      = 1'b1;
                    r.full_notice = 1'b1;
                end
                charge_ticks = charge_ticks + 16'd1;
                if (charge_ticks % REMINDER_PERIOD == 0)
                    r.reminder = notified ? REM_FULL : REM_CHARGING;
            end else begin
                notified     = 1'b0;
                full_flag    = 1'b0;
                charge_ticks = 16'd0;
            end
            r.display_update = (last_deb != t.charging_pin);
            last_deb         = t.charging_pin;
        end
        r.play_charging_sound = r.charge_started && !t.alarm_wakeup;
        r.play_full_sound     = r.full_notice && !t.alarm_wakeup;
        r.charging_state      = last_deb;
        r.full_confirmed      = full_flag;
        return r;
    endfunction

    task automatic report_fault(string msg);
        $display("tick check: %s", msg);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_fault($sformatf("result %0d %s got %0d expected %0d",
                                   result_no, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            deb_ticks     = DEBOUNCE_TICKS_RST;
            confirm_ticks = FULL_CONFIRM_TICKS_RST;
            full_pct      = FULL_PERCENT_RST;
            pin_en        = FULL_PIN_ENABLE_RST;
            last_raw      = 1'b0;
            last_deb      = 1'b0;
            stable_cnt    = 8'd0;
            seen_cnt      = 8'd0;
            absent_cnt    = 8'd0;
            full_flag     = 1'b0;
            notified      = 1'b0;
            charge_ticks  = 16'd0;
            expected_ticks.delete();
            o_pending     = 0;
            o_fail_count  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE_TICKS:     deb_ticks     = i_cfg_data;
                    CFG_FULL_CONFIRM_TICKS: confirm_ticks = i_cfg_data;
                    CFG_FULL_PERCENT:       full_pct      = i_cfg_data[6:0];
                    CFG_FULL_PIN_ENABLE:    pin_en        = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    report_fault($sformatf("result %0d arrived with nothing expected",
                                           result_no));
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("charge_started", i_out.charge_started, want.charge_started);
                    check_field("play_charging_sound", i_out.play_charging_sound,
                                want.play_charging_sound);
                    check_field("full_notice", i_out.full_notice, want.full_notice);
                    check_field("play_full_sound", i_out.play_full_sound,
                                want.play_full_sound);
                    check_field("reminder", i_out.reminder, want.reminder);
                    check_field("display_update", i_out.display_update, want.display_update);
                    check_field("charging_state", i_out.charging_state, want.charging_state);
                    check_field("full_confirmed", i_out.full_confirmed, want.full_confirmed);
                end
                result_no = result_no + 1;
            end
            if (i_in_valid && !i_in_stall)
                expected_ticks.push_back(predict_tick(i_in));
            o_pending = expected_ticks.size();
        end
    end

endmodule

/* bench/charger_status_debounce_monitor_unit_test.sv */
`timescale 1ns / 1ps

module charger_status_debounce_monitor_unit_test;
    import csdm_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_beat   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_beat;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    t_cfg_index cfg_index = CFG_DEBOUNCE_TICKS;
    logic [7:0] cfg_data  = 8'd0;
    int         fail_count;
    int         pending;
    int         stall_run = 0;

    always #5 clk = ~clk;

    charger_status_debounce_monitor_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    charge_tick_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls in bursts, mostly short, now and then long runs either way
    always @(posedge clk) begin
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            out_stall <= ($urandom_range(0, 9) < 4);
            stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 3);
        end
    end

    function automatic t_in_item make_tick(logic chg, logic fpin, logic [6:0] pct,
                                           logic alarm);
        t_in_item t;
        t.charging_pin    = chg;
        t.full_pin        = fpin;
        t.battery_percent = pct;
        t.alarm_wakeup    = alarm;
        return t;
    endfunction

    function automatic int pick_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_tick(t_in_item t, int gap);
        in_beat  <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every beat in flight has come out
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] deb, logic [7:0] confirm, logic [6:0] pct,
                             logic pin_en, int count);
        int         seg_left;
        logic       chg_level;
        logic       full_level;
        logic       alarm_level;
        logic       noisy_chg;
        logic       noisy_full;
        logic       calm;
        logic [6:0] pct_level;
        logic       chg;
        logic       fpin;
        logic [6:0] pct_now;
        seg_left  = 0;
        chg_level = 1'b0;
        pct_level = 7'd0;
        noisy_chg = 1'b0;
        noisy_full = 1'b0;
        full_level = 1'b0;
        alarm_level = 1'b0;
        calm = 1'b0;
        drain();
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_FULL_CONFIRM_TICKS, confirm);
        write_reg(CFG_FULL_PERCENT, {1'b0, pct});
        write_reg(CFG_FULL_PIN_ENABLE, {7'd0, pin_en});
        cfg_valid <= 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            if (seg_left == 0) begin
                // mostly held levels long enough to pass debounce, some glitch noise
                chg_level   = ($urandom_range(0, 4) == 0) ? chg_level : ~chg_level;
                noisy_chg   = ($urandom_range(0, 9) == 0);
                noisy_full  = ($urandom_range(0, 1) == 0);
                full_level  = ($urandom_range(0, 2) != 0);
                alarm_level = ($urandom_range(0, 3) == 0);
                calm        = ($urandom_range(0, 3) == 0);
                pct_level   = 7'($urandom_range(0, 100));
                seg_left    = ($urandom_range(0, 3) == 0) ? deb + $urandom_range(20, 300)
                                                          : $urandom_range(1, 40);
            end
            seg_left = seg_left - 1;
            chg  = noisy_chg ? 1'($urandom_range(0, 1)) : chg_level;
            fpin = (noisy_full && $urandom_range(0, 15) == 0) ? ~full_level : full_level;
            if ($urandom_range(0, 1) && pct_level < 7'd100) pct_level = pct_level + 7'd1;
            pct_now = ($urandom_range(0, 49) == 0) ? 7'($urandom_range(0, 127)) : pct_level;
            send_tick(make_tick(chg, fpin, pct_now, alarm_level), pick_gap(calm));
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks at the percent extremes
        send_tick(make_tick(1'b0, 1'b0, 7'd0, 1'b0), pick_gap(1'b0));
        send_tick(make_tick(1'b0, 1'b1, 7'd127, 1'b1), pick_gap(1'b0));
        // charge start with percent over threshold, alarm on the accepting tick
        for (int i = 0; i < 4; i++)
            send_tick(make_tick(1'b1, 1'b1, 7'd100, 1'(i == 2)), pick_gap(1'b0));
        // single low tick shorter than debounce
        send_tick(make_tick(1'b0, 1'b1, 7'd64, 1'b0), pick_gap(1'b0));
        // full pin held past the confirm count
        for (int i = 0; i < 8; i++)
            send_tick(make_tick(1'b1, 1'b1, 7'(i * 13), 1'b0), pick_gap(1'b0));
        // charger removed: notice and flag clear
        for (int i = 0; i < 4; i++)
            send_tick(make_tick(1'b0, 1'b0, 7'd31, 1'(i % 2)), pick_gap(1'b0));
        // recharge at low percent, notice comes from the confirmed full pin
        for (int i = 0; i < 6; i++)
            send_tick(make_tick(1'b1, 1'b1, 7'd1, 1'b0), pick_gap(1'b0));

        run_phase(8'd1, 8'd0, 7'd100, 1'b1, 250);
        run_phase(8'd0, 8'd0, 7'd0, 1'b1, 150);
        run_phase(8'd255, 8'd254, 7'd50, 1'b1, 500);
        run_phase(8'd2, 8'd3, 7'd60, 1'b0, 200);
        run_phase(8'd4, 8'd10, 7'd80, 1'b1, 250);
        run_phase(DEBOUNCE_TICKS_RST, FULL_CONFIRM_TICKS_RST, FULL_PERCENT_RST,
                  FULL_PIN_ENABLE_RST, 150);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
